// File: rtl/core/uv_sphere_vertex_index_gen_assert.svh
// assertion macros for the uv sphere vertex generator
`ifndef UV_SPHERE_VERTEX_INDEX_GEN_ASSERT_SVH
`define UV_SPHERE_VERTEX_INDEX_GEN_ASSERT_SVH

// same-cycle implication
`define USV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("usv assertion failed");

// next-cycle implication
`define USV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("usv assertion failed");

`endif

// File: rtl/core/usv_pkg.sv
// shared constants, types and tables of the uv sphere vertex generator
package usv_pkg;

  localparam int MaxSegmentsDef = 256;
  localparam int FracBitsDef    = 15;
  localparam int PhaseBits      = 24;
  localparam int CordicSteps    = 20;
  localparam int TrigFrac       = 30;
  localparam int DivNumW        = 33;
  localparam int DivDenW        = 10;
  localparam logic signed [31:0] CordicGainInv = 32'sd652032874;

  typedef enum logic {
    REG_LAT_SEGMENTS = 1'b0,
    REG_LON_SEGMENTS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] row;
    logic [8:0] col;
  } side_t;

  // arctangent of 2^-i in phase units of 2^24 per turn
  function automatic logic signed [24:0] atan_phase(input int unsigned i);
    logic signed [24:0] r;
    r = 25'sd0;
    unique case (i)
      0:  r = 25'sd2097152;
      1:  r = 25'sd1238021;
      2:  r = 25'sd654136;
      3:  r = 25'sd332050;
      4:  r = 25'sd166669;
      5:  r = 25'sd83416;
      6:  r = 25'sd41718;
      7:  r = 25'sd20860;
      8:  r = 25'sd10430;
      9:  r = 25'sd5215;
      10: r = 25'sd2608;
      11: r = 25'sd1304;
      12: r = 25'sd652;
      13: r = 25'sd326;
      14: r = 25'sd163;
      15: r = 25'sd81;
      16: r = 25'sd41;
      17: r = 25'sd20;
      18: r = 25'sd10;
      19: r = 25'sd5;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/uv_sphere_vertex_index_gen.sv
// Top level of the uv sphere vertex and quad index generator.
// Pipeline of 58 stages (input, 33-stage divider, 22-stage cordic, multiply,
// round and index stage), from the accepting edge to the output register.
// Throughput: one item per cycle; the whole pipeline advances when the
// output register is empty or being taken. Reset clears valid bits and sets
// both segment registers to 16.
module uv_sphere_vertex_index_gen #(
  parameter int MAX_SEGMENTS = usv_pkg::MaxSegmentsDef,
  parameter int FRAC_BITS    = usv_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // lat_index [7:0], lon_index [16:8]
  input  logic [23:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x [15:0], pos_y [31:16], pos_z [47:32], tex_u [64:48], tex_v [81:65],
  // idx_left_top [98:82], idx_right_top [115:99], idx_right_bottom [132:116],
  // idx_left_bottom [149:133]
  output logic [151:0] m_axis_tdata,
  // quad_valid [0]
  output logic         m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

`include "uv_sphere_vertex_index_gen_assert.svh"

  localparam int DivLat  = usv_pkg::DivNumW;
  localparam int CorLat  = usv_pkg::CordicSteps + 2;
  localparam int Stages  = 1 + DivLat + CorLat + 2;
  localparam int Last    = Stages - 1;
  localparam int TexLen  = CorLat + 1;
  localparam int ShM     = 2 * usv_pkg::TrigFrac - FRAC_BITS;
  localparam int ShY     = usv_pkg::TrigFrac - FRAC_BITS;
  localparam logic signed [63:0] RndM = 64'sd1 <<< (ShM - 1);
  localparam logic signed [63:0] RndY = (ShY == 0) ? 64'sd0 : (64'sd1 <<< (ShY - 1));

  // configuration registers
  logic [8:0] lat_q, lon_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= 9'd16;
      lon_q <= 9'd16;
    end else if (wr_en) begin
      unique case (usv_pkg::reg_idx_e'(paddr[2]))
        usv_pkg::REG_LAT_SEGMENTS: lat_q <= pwdata[8:0];
        usv_pkg::REG_LON_SEGMENTS: lon_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (usv_pkg::reg_idx_e'(paddr[2]))
      usv_pkg::REG_LAT_SEGMENTS: prdata = {23'd0, lat_q};
      usv_pkg::REG_LON_SEGMENTS: prdata = {23'd0, lon_q};
      default: prdata = '0;
    endcase
  end

  // clamped grid size
  logic [31:0] max_w;
  logic [8:0]  rows, cols;

  assign max_w = 32'(MAX_SEGMENTS);
  assign rows  = (lat_q < 9'd2) ? 9'd2 :
                 ((32'(lat_q) > max_w) ? 9'(max_w) : lat_q);
  assign cols  = (lon_q < 9'd1) ? 9'd1 :
                 ((32'(lon_q) > max_w) ? 9'(max_w) : lon_q);

  // pipeline advance and valid bits
  logic              en;
  logic [Stages-1:0] vld_q;

  assign en            = !vld_q[Last] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Last];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], s_axis_tvalid};
    end
  end

  // input stage and grid point delay line
  usv_pkg::side_t side_q [Last];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].row <= s_axis_tdata[7:0];
      side_q[0].col <= s_axis_tdata[16:8];
      for (int k = 1; k < Last; k++) side_q[k] <= side_q[k-1];
    end
  end

  // dividends and divisors
  logic [usv_pkg::DivNumW-1:0] num_t, num_p, num_u, num_v;
  logic [usv_pkg::DivDenW-1:0] den_t, den_c, den_r;
  logic [usv_pkg::DivNumW-1:0] quo_t, quo_p, quo_u, quo_v;

  assign num_t = (33'(side_q[0].row) << 24) + 33'(rows - 9'd1);
  assign num_p = (33'(side_q[0].col) << 24) + 33'(cols >> 1);
  assign num_u = (33'(side_q[0].row) << 16) + 33'(rows >> 1);
  assign num_v = (33'(side_q[0].col) << 16) + 33'(cols >> 1);
  assign den_t = 10'(rows - 9'd1) << 1;
  assign den_c = 10'(cols);
  assign den_r = 10'(rows);

  usv_div u_div_t (.clk_i, .en_i(en), .num_i(num_t), .den_i(den_t), .quo_o(quo_t));
  usv_div u_div_p (.clk_i, .en_i(en), .num_i(num_p), .den_i(den_c), .quo_o(quo_p));
  usv_div u_div_u (.clk_i, .en_i(en), .num_i(num_u), .den_i(den_r), .quo_o(quo_u));
  usv_div u_div_v (.clk_i, .en_i(en), .num_i(num_v), .den_i(den_c), .quo_o(quo_v));

  // sine and cosine of both angles
  logic signed [31:0] st, ct, sp, cp;

  usv_cordic u_cor_t (
    .clk_i, .en_i(en), .phase_i(quo_t[usv_pkg::PhaseBits-1:0]), .sin_o(st), .cos_o(ct)
  );
  usv_cordic u_cor_p (
    .clk_i, .en_i(en), .phase_i(quo_p[usv_pkg::PhaseBits-1:0]), .sin_o(sp), .cos_o(cp)
  );

  // saturated texture coordinates, delayed alongside the cordic
  logic [16:0] tu_q [TexLen];
  logic [16:0] tv_q [TexLen];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tu_q[0] <= (quo_u > 33'd65536) ? 17'd65536 : quo_u[16:0];
      tv_q[0] <= (quo_v > 33'd65536) ? 17'd65536 : quo_v[16:0];
      for (int k = 1; k < TexLen; k++) begin
        tu_q[k] <= tu_q[k-1];
        tv_q[k] <= tv_q[k-1];
      end
    end
  end

  // product stage
  logic signed [63:0] prod_x_q, prod_z_q, ct_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q <= st * cp;
      prod_z_q <= st * sp;
      ct_q     <= 64'(ct);
    end
  end

  // rounding, saturation and quad indices
  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic [15:0] r;
    r = v[15:0];
    if (v > 64'sd32767) r = 16'h7fff;
    else if (v < -64'sd32768) r = 16'h8000;
    return r;
  endfunction

  logic signed [63:0] rx, ry, rz;
  logic [8:0]         row_w, col_w;
  logic [9:0]         stride;
  logic [17:0]        lt, lb;
  logic               qv;

  assign rx     = (prod_x_q + RndM) >>> ShM;
  assign rz     = (prod_z_q + RndM) >>> ShM;
  assign ry     = (ct_q + RndY) >>> ShY;
  assign row_w  = {1'b0, side_q[Last-1].row};
  assign col_w  = side_q[Last-1].col;
  assign stride = 10'(cols) + 10'd1;
  assign lt     = 18'(row_w * stride) + 18'(col_w);
  assign lb     = lt + 18'(stride);
  assign qv     = (row_w < rows - 9'd1) && (col_w < cols);

  logic [151:0] out_q;
  logic         quad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q[15:0]    <= sat16(rx);
      out_q[31:16]   <= sat16(ry);
      out_q[47:32]   <= sat16(rz);
      out_q[64:48]   <= tu_q[TexLen-1];
      out_q[81:65]   <= tv_q[TexLen-1];
      out_q[98:82]   <= qv ? lt[16:0] : 17'd0;
      out_q[115:99]  <= qv ? 17'(lt + 18'd1) : 17'd0;
      out_q[132:116] <= qv ? 17'(lb + 18'd1) : 17'd0;
      out_q[149:133] <= qv ? lb[16:0] : 17'd0;
      out_q[151:150] <= 2'b00;
      quad_q         <= qv;
    end
  end

  assign m_axis_tdata = out_q;
  assign m_axis_tuser = quad_q;

  // checks
  `USV_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready, vld_q[0])
  `USV_ASSERT_SAME(a_no_quad_zero_idx, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tuser, m_axis_tdata[149:82] == 68'd0)
  `USV_ASSERT_SAME(a_right_top_next, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser,
    m_axis_tdata[115:99] == 17'(m_axis_tdata[98:82] + 17'd1))

endmodule

// File: rtl/core/usv_div.sv
// pipelined restoring divider, one quotient bit per stage
module usv_div #(
  parameter int NumW = usv_pkg::DivNumW,
  parameter int DenW = usv_pkg::DivDenW
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o
);

  logic [DenW-1:0] rem_q [NumW];
  logic [NumW-1:0] quo_q [NumW];
  logic [NumW-1:0] num_q [NumW];
  logic [DenW-1:0] den_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW-1:0] rem_in;
    logic [NumW-1:0] quo_in;
    logic [NumW-1:0] num_in;
    logic [DenW-1:0] den_in;
    logic [DenW:0]   trial;
    logic            fits;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
    end

    // shift in next dividend bit and try a subtract
    assign trial = {rem_in, num_in[NumW-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? DenW'(trial - {1'b0, den_in}) : DenW'(trial);
        quo_q[k] <= {quo_in[NumW-2:0], fits};
        num_q[k] <= {num_in[NumW-2:0], 1'b0};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[NumW-1];

endmodule

// File: rtl/core/usv_cordic.sv
// pipelined rotation cordic, phase in, sine and cosine at 30 fraction bits
module usv_cordic (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [usv_pkg::PhaseBits-1:0]       phase_i,
  output logic signed [31:0]                  sin_o,
  output logic signed [31:0]                  cos_o
);

  localparam int N = usv_pkg::CordicSteps;

  logic signed [31:0] x_q [N+1];
  logic signed [31:0] y_q [N+1];
  logic signed [24:0] z_q [N+1];
  logic [1:0]         quad_q [N+1];
  logic signed [31:0] sin_q, cos_q;

  // split off quadrant, start vector
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= usv_pkg::CordicGainInv;
      y_q[0]    <= 32'sd0;
      z_q[0]    <= $signed({3'b000, phase_i[usv_pkg::PhaseBits-3:0]});
      quad_q[0] <= phase_i[usv_pkg::PhaseBits-1:usv_pkg::PhaseBits-2];
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [31:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - usv_pkg::atan_phase(i);
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + usv_pkg::atan_phase(i);
        end
        quad_q[i+1] <= quad_q[i];
      end
    end
  end

  // quadrant symmetry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (quad_q[N])
        2'd0: begin cos_q <= x_q[N];  sin_q <= y_q[N];  end
        2'd1: begin cos_q <= -y_q[N]; sin_q <= x_q[N];  end
        2'd2: begin cos_q <= -x_q[N]; sin_q <= -y_q[N]; end
        default: begin cos_q <= y_q[N]; sin_q <= -x_q[N]; end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// File: test/tb_uv_sphere_vertex_index_gen.sv
// self-checking testbench for the uv sphere vertex and quad index generator
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_index_gen;

  localparam int LatencyCycles = 58;
  localparam int LimitCycles   = 400000;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               quad_valid;
    logic [16:0]        idx_lt;
    logic [16:0]        idx_rt;
    logic [16:0]        idx_rb;
    logic [16:0]        idx_lb;
  } vertex_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [23:0]  s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  uv_sphere_vertex_index_gen dut (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // grid settings as the block sees them
  logic [8:0] lat_segs = 9'd16;
  logic [8:0] lon_segs = 9'd16;

  usv_pkg::side_t grid_points[$];
  vertex_t        vertex_expected[$];
  usv_pkg::side_t cur_pt;
  logic           offer_busy = 1'b0;
  logic           in_fire = 1'b0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             recv_hold = 0;
  int             fail_count = 0;
  int             cycle_count = 0;

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_shift(longint v, int n);
    return floor_shift(v + (longint'(1) <<< (n - 1)), n);
  endfunction

  function automatic longint sat_q15(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // rotation cordic over a 2^24 phase turn, results at 30 fraction bits
  task automatic cordic_sincos(input longint phase, output longint s, output longint c);
    longint x, y, z, nx, ny;
    int quadrant;
    quadrant = int'((phase >> (usv_pkg::PhaseBits - 2)) & 3);
    z = phase & ((longint'(1) << (usv_pkg::PhaseBits - 2)) - 1);
    x = longint'(usv_pkg::CordicGainInv);
    y = 0;
    for (int i = 0; i < usv_pkg::CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        z -= longint'(usv_pkg::atan_phase(i));
      end else begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        z += longint'(usv_pkg::atan_phase(i));
      end
      x = nx;
      y = ny;
    end
    case (quadrant)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint tex_ratio(longint num, longint den);
    longint r;
    r = ((num << 16) + den / 2) / den;
    return (r > 65536) ? 65536 : r;
  endfunction

  task automatic compute_vertex(input usv_pkg::side_t pt, output vertex_t v);
    longint rows, cols, row, col, den_t, ph_t, ph_p, st, ct, sp, cp, lt, lb;
    rows = (lat_segs < 2) ? 2 : ((lat_segs > 256) ? 256 : lat_segs);
    cols = (lon_segs < 1) ? 1 : ((lon_segs > 256) ? 256 : lon_segs);
    row = pt.row;
    col = pt.col;
    den_t = 2 * (rows - 1);
    ph_t = (((row << usv_pkg::PhaseBits) + den_t / 2) / den_t) &
           ((1 << usv_pkg::PhaseBits) - 1);
    ph_p = (((col << usv_pkg::PhaseBits) + cols / 2) / cols) &
           ((1 << usv_pkg::PhaseBits) - 1);
    cordic_sincos(ph_t, st, ct);
    cordic_sincos(ph_p, sp, cp);
    v.pos_x = 16'(sat_q15(round_shift(st * cp,
                                      2 * usv_pkg::TrigFrac - usv_pkg::FracBitsDef)));
    v.pos_y = 16'(sat_q15(round_shift(ct, usv_pkg::TrigFrac - usv_pkg::FracBitsDef)));
    v.pos_z = 16'(sat_q15(round_shift(st * sp,
                                      2 * usv_pkg::TrigFrac - usv_pkg::FracBitsDef)));
    v.tex_u = 17'(tex_ratio(row, rows));
    v.tex_v = 17'(tex_ratio(col, cols));
    v.quad_valid = (row < rows - 1) && (col < cols);
    lt = row * (cols + 1) + col;
    lb = (row + 1) * (cols + 1) + col;
    v.idx_lt = v.quad_valid ? 17'(lt) : '0;
    v.idx_rt = v.quad_valid ? 17'(lt + 1) : '0;
    v.idx_rb = v.quad_valid ? 17'(lb + 1) : '0;
    v.idx_lb = v.quad_valid ? 17'(lb) : '0;
  endtask

  // predict on each accepted input transaction
  always @(posedge clk_i) begin
    vertex_t v;
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      compute_vertex(cur_pt, v);
      vertex_expected = {vertex_expected, v};
      offer_busy = 1'b0;
    end
  end

  // driver: offer the next queued grid point once the last one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (grid_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_pt = grid_points.pop_front();
        offer_busy = 1'b1;
        s_axis_tdata <= {7'd0, cur_pt.col, cur_pt.row};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready with random idling and a long hold-off
  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    vertex_t e;
    vertex_t a;
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.pos_x = m_axis_tdata[15:0];
      a.pos_y = m_axis_tdata[31:16];
      a.pos_z = m_axis_tdata[47:32];
      a.tex_u = m_axis_tdata[64:48];
      a.tex_v = m_axis_tdata[81:65];
      a.idx_lt = m_axis_tdata[98:82];
      a.idx_rt = m_axis_tdata[115:99];
      a.idx_rb = m_axis_tdata[132:116];
      a.idx_lb = m_axis_tdata[149:133];
      a.quad_valid = m_axis_tuser;
      if (vertex_expected.size() == 0) begin
        $display("%0t: unexpected vertex transaction %p", $time, a);
        fail_count++;
      end else begin
        e = vertex_expected.pop_front();
        if (e != a) begin
          $display("%0t: vertex mismatch expected %p actual %p", $time, e, a);
          fail_count++;
        end
      end
    end
    if (cycle_count > LimitCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(input usv_pkg::reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(idx) << 2;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == usv_pkg::REG_LAT_SEGMENTS) lat_segs = value[8:0];
    else lon_segs = value[8:0];
  endtask

  task automatic drain();
    while (grid_points.size() > 0 || offer_busy || vertex_expected.size() > 0)
      @(negedge clk_i);
    repeat (LatencyCycles + 8) @(negedge clk_i);
  endtask

  task automatic add_point(input int row, input int col);
    usv_pkg::side_t pt;
    pt.row = 8'(row);
    pt.col = 9'(col);
    grid_points = {grid_points, pt};
  endtask

  // mostly in-grid points, some beyond the grid and full-range noise
  task automatic add_random(input int count);
    int rows, cols;
    rows = (lat_segs < 2) ? 2 : ((lat_segs > 256) ? 256 : lat_segs);
    cols = (lon_segs < 1) ? 1 : ((lon_segs > 256) ? 256 : lon_segs);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7)
        add_point($urandom_range(rows - 1 > 255 ? 255 : rows - 1), $urandom_range(cols));
      else
        add_point($urandom_range(255), $urandom_range(511));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset grid, corners, poles, seam and out-of-grid points
    add_point(0, 0);
    add_point(15, 16);
    add_point(14, 15);
    add_point(8, 4);
    add_point(7, 8);
    add_point(15, 0);
    add_point(16, 17);
    add_point(255, 511);
    add_point(255, 0);
    add_point(0, 511);
    add_point(170, 341);
    add_point(85, 170);
    drain();

    // register extremes: below the minimum (clamped up), maximum and above maximum
    reg_write(usv_pkg::REG_LAT_SEGMENTS, 32'd0);
    reg_write(usv_pkg::REG_LON_SEGMENTS, 32'd0);
    add_point(0, 0);
    add_point(1, 1);
    add_point(0, 1);
    add_point(2, 2);
    drain();
    reg_write(usv_pkg::REG_LAT_SEGMENTS, 32'd256);
    reg_write(usv_pkg::REG_LON_SEGMENTS, 32'd256);
    add_point(254, 255);
    add_point(255, 256);
    add_point(128, 128);
    add_point(0, 256);
    drain();
    reg_write(usv_pkg::REG_LAT_SEGMENTS, 32'h1FF);
    reg_write(usv_pkg::REG_LON_SEGMENTS, 32'hFFFF_FFFF);
    add_point(255, 255);
    add_point(3, 300);
    drain();

    // random phases with varied grid sizes and idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : ((phase == 1) ? 55 : 0);
      recv_idle_pct = (phase == 0) ? 55 : ((phase == 1) ? 18 : 0);
      for (int k = 0; k < 4; k++) begin
        reg_write(usv_pkg::REG_LAT_SEGMENTS, $urandom_range(k == 0 ? 256 : 40, 2));
        reg_write(usv_pkg::REG_LON_SEGMENTS, $urandom_range(k == 0 ? 256 : 40, 1));
        add_random(64);
        if (phase == 2 && k == 0) recv_hold = 300;
        drain();
      end
    end

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/usv_pkg.sv
rtl/core/usv_div.sv
rtl/core/usv_cordic.sv
rtl/core/uv_sphere_vertex_index_gen.sv
test/tb_uv_sphere_vertex_index_gen.sv
